// ===== hw/rtl/mpa_pkg.sv =====
// ----------------------------------------------------------------------------
// mpa_pkg: shared types and constants for max pooling with argmax
// Field widths, register codes, reset values and the front/back request.
// ----------------------------------------------------------------------------
`default_nettype none

package mpa_pkg;

  localparam int VAL_W   = 16;  // sample / maximum width
  localparam int OUT_W   = 10;  // position fields on the result port
  localparam int FW      = 13;  // internal position width (fits MAX 4096)
  localparam int DIM_W   = 14;  // plane dimension arithmetic
  localparam int SLOT_W  = 3;   // row slot (MAX_KERNEL up to 8)
  localparam int K_W     = 4;   // effective kernel size
  localparam int CFG_W   = 11;  // configuration data width
  localparam int IDX_W   = 3;   // configuration index width
  localparam int Q_DEPTH = 4;   // result queue depth

  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_MAX_HEIGHT = 1024;
  localparam int DEF_MAX_KERNEL = 4;

  localparam logic [CFG_W-1:0] RST_HEIGHT = 11'd1024;
  localparam logic [CFG_W-1:0] RST_WIDTH  = 11'd1024;
  localparam logic [2:0]       RST_KERNEL = 3'd2;
  localparam logic [2:0]       RST_STRIDE = 3'd2;

  typedef enum logic [IDX_W-1:0] {
    REG_HEIGHT = 3'd0,
    REG_WIDTH  = 3'd1,
    REG_KERNEL = 3'd2,
    REG_STRIDE = 3'd3
  } reg_idx_t;

  // Request from front to back: one per accepted sample.
  typedef struct packed {
    logic                    wr;    // horizontal window finished: store row max
    logic                    emit;  // full 2-D window finished
    logic [SLOT_W-1:0]       slot;  // line buffer of the current row
    logic [FW-1:0]           ow;
    logic [FW-1:0]           oh;
    logic [FW-1:0]           row;
    logic [FW-1:0]           col;   // column of the row winner
    logic signed [VAL_W-1:0] val;   // row maximum
    logic                    last;
  } hres_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] val;
    logic [OUT_W-1:0]        wrow;
    logic [OUT_W-1:0]        wcol;
    logic [OUT_W-1:0]        orow;
    logic [OUT_W-1:0]        ocol;
    logic                    last;
  } res_t;

endpackage

`default_nettype wire

// ===== hw/rtl/max_pool_2d_with_argmax_top.sv =====
// ----------------------------------------------------------------------------
// max_pool_2d_with_argmax_top: streaming 2-D max pooling with argmax
// Samples arrive in raster order on a queue-style input (push / full).
// Each finished window leaves on a queue-style output (empty / pop) with
// its maximum, the plane row and column of the winner (earliest on ties),
// its output row and column, and a flag on the last window of the plane.
// Configuration goes through a valid/ready port (cfg_ready is always high):
// index 0 height, 1 width, 2 kernel, 3 stride. A write to one of those
// four indices restarts a plane. Throughput: one sample per cycle while
// full is low. Row maxima go into one line buffer RAM per kernel row; when
// a window closes, its k rows are merged in the merge stage and queued.
// The result queue holds four entries; when the receiver stalls, full
// rises once the queue plus the merge stage can take no more.
// Reset: registers return to 1024, 1024, 2, 2, position to row 0 col 0,
// queue empty. Line buffers need no clearing.
// ----------------------------------------------------------------------------
`default_nettype none

module max_pool_2d_with_argmax_top #(
  parameter int MAX_WIDTH  = mpa_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = mpa_pkg::DEF_MAX_HEIGHT,
  parameter int MAX_KERNEL = mpa_pkg::DEF_MAX_KERNEL
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             push,
  output logic                                  full,
  input  wire logic signed [mpa_pkg::VAL_W-1:0] sample,
  output logic                                  empty,
  input  wire logic                             pop,
  output logic signed [mpa_pkg::VAL_W-1:0]      max_value,
  output logic      [mpa_pkg::OUT_W-1:0]        winner_row,
  output logic      [mpa_pkg::OUT_W-1:0]        winner_col,
  output logic      [mpa_pkg::OUT_W-1:0]        out_row,
  output logic      [mpa_pkg::OUT_W-1:0]        out_col,
  output logic                                  plane_done,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [mpa_pkg::IDX_W-1:0]        cfg_index,
  input  wire logic [mpa_pkg::CFG_W-1:0]        cfg_data
);

  mpa_pkg::hres_t            hres;
  mpa_pkg::res_t             res;
  logic [mpa_pkg::K_W-1:0]   k_eff;
  logic                      accept;

  assign cfg_ready = 1'b1;
  assign accept    = push && !full;

  mpa_front #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT),
    .MAX_KERNEL(MAX_KERNEL)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .sample   (sample),
    .cfg_we   (cfg_valid && cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .k_eff    (k_eff),
    .hres     (hres)
  );

  mpa_back #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_KERNEL(MAX_KERNEL)
  ) u_back (
    .clk  (clk),
    .rst  (rst),
    .hres (hres),
    .k_eff(k_eff),
    .pop  (pop),
    .full (full),
    .empty(empty),
    .res  (res)
  );

  assign max_value  = res.val;
  assign winner_row = res.wrow;
  assign winner_col = res.wcol;
  assign out_row    = res.orow;
  assign out_col    = res.ocol;
  assign plane_done = res.last;

endmodule

`default_nettype wire

// ===== hw/rtl/mpa_ram.sv =====
// ----------------------------------------------------------------------------
// mpa_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module mpa_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== hw/rtl/mpa_front.sv =====
// ----------------------------------------------------------------------------
// mpa_front: position tracking and row-wise window maximum
// Holds configuration, walks the raster, keeps the last samples of the row
// and classifies each sample into a request for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module mpa_front #(
  parameter int MAX_WIDTH  = mpa_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = mpa_pkg::DEF_MAX_HEIGHT,
  parameter int MAX_KERNEL = mpa_pkg::DEF_MAX_KERNEL
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           accept,
  input  wire logic signed [mpa_pkg::VAL_W-1:0] sample,
  input  wire logic                           cfg_we,
  input  wire logic [mpa_pkg::IDX_W-1:0]      cfg_index,
  input  wire logic [mpa_pkg::CFG_W-1:0]      cfg_data,
  output logic      [mpa_pkg::K_W-1:0]        k_eff,
  output mpa_pkg::hres_t                      hres
);

  localparam int RW = $clog2(MAX_HEIGHT);
  localparam int CW = $clog2(MAX_WIDTH);
  localparam int SW = (MAX_KERNEL > 1) ? $clog2(MAX_KERNEL) : 1;
  localparam int DW = mpa_pkg::DIM_W;
  localparam int FW = mpa_pkg::FW;

  logic [mpa_pkg::CFG_W-1:0] height, width;
  logic [2:0]                kernel, stride;
  logic [RW-1:0]             r, oh;
  logic [CW-1:0]             c, ow;
  logic [SW-1:0]             slot;
  logic [DW-1:0]             end_r, end_c;
  logic signed [mpa_pkg::VAL_W-1:0] hist [MAX_KERNEL];

  logic                      cfg_hit;
  logic [2:0]                kernel_src, s_eff;
  logic [DW-1:0]             h_eff, w_eff, k_m1;
  logic                      col_hit, row_hit, col_end, row_end, col_last, row_last;
  logic signed [mpa_pkg::VAL_W-1:0] best_v;
  logic [mpa_pkg::SLOT_W:0]  best_i;

  assign cfg_hit = cfg_we && (cfg_index == mpa_pkg::REG_HEIGHT ||
                              cfg_index == mpa_pkg::REG_WIDTH  ||
                              cfg_index == mpa_pkg::REG_KERNEL ||
                              cfg_index == mpa_pkg::REG_STRIDE);

  always_comb begin
    kernel_src = (cfg_we && cfg_index == mpa_pkg::REG_KERNEL) ? cfg_data[2:0] : kernel;
    if (kernel_src == 3'd0) begin
      k_eff = mpa_pkg::K_W'(1);
    end else if (mpa_pkg::K_W'(kernel_src) > mpa_pkg::K_W'(MAX_KERNEL)) begin
      k_eff = mpa_pkg::K_W'(MAX_KERNEL);
    end else begin
      k_eff = mpa_pkg::K_W'(kernel_src);
    end
    k_m1  = DW'(k_eff) - DW'(1);
    s_eff = (stride == 3'd0) ? 3'd1 : stride;

    if (height == '0) begin
      h_eff = DW'(1);
    end else if (DW'(height) > DW'(MAX_HEIGHT)) begin
      h_eff = DW'(MAX_HEIGHT);
    end else begin
      h_eff = DW'(height);
    end
    if (width == '0) begin
      w_eff = DW'(1);
    end else if (DW'(width) > DW'(MAX_WIDTH)) begin
      w_eff = DW'(MAX_WIDTH);
    end else begin
      w_eff = DW'(width);
    end

    col_hit  = DW'(c) == end_c;
    row_hit  = DW'(r) == end_r;
    col_end  = DW'(c) == w_eff - DW'(1);
    row_end  = DW'(r) == h_eff - DW'(1);
    col_last = (end_c + DW'(s_eff)) >= w_eff;
    row_last = (end_r + DW'(s_eff)) >= h_eff;
  end

  // Row maximum over the last k samples, oldest first so ties keep the earliest.
  always_comb begin
    logic found;
    logic signed [mpa_pkg::VAL_W-1:0] cand;
    found  = 1'b0;
    best_v = sample;
    best_i = '0;
    for (int i = MAX_KERNEL - 1; i >= 0; i--) begin
      cand = (i == 0) ? sample : hist[(i > 0) ? i - 1 : 0];
      if (mpa_pkg::K_W'(i) < k_eff) begin
        if (!found || cand > best_v) begin
          best_v = cand;
          best_i = (mpa_pkg::SLOT_W + 1)'(i);
          found  = 1'b1;
        end
      end
    end
  end

  always_comb begin
    hres.wr   = accept && col_hit;
    hres.emit = accept && col_hit && row_hit;
    hres.slot = mpa_pkg::SLOT_W'(slot);
    hres.ow   = FW'(ow);
    hres.oh   = FW'(oh);
    hres.row  = FW'(r);
    hres.col  = FW'(c) - FW'(best_i);
    hres.val  = best_v;
    hres.last = row_last && col_last;
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      hist[0] <= sample;
      for (int i = 1; i < MAX_KERNEL; i++) begin
        hist[i] <= hist[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      height <= mpa_pkg::RST_HEIGHT;
      width  <= mpa_pkg::RST_WIDTH;
      kernel <= mpa_pkg::RST_KERNEL;
      stride <= mpa_pkg::RST_STRIDE;
      r      <= '0;
      c      <= '0;
      oh     <= '0;
      ow     <= '0;
      slot   <= '0;
      end_r  <= DW'(mpa_pkg::RST_KERNEL) - DW'(1);
      end_c  <= DW'(mpa_pkg::RST_KERNEL) - DW'(1);
    end else if (cfg_hit) begin
      unique case (cfg_index)
        mpa_pkg::REG_HEIGHT: height <= cfg_data;
        mpa_pkg::REG_WIDTH:  width  <= cfg_data;
        mpa_pkg::REG_KERNEL: kernel <= cfg_data[2:0];
        default:             stride <= cfg_data[2:0];
      endcase
      // restart a new plane, abandon windows in flight
      r     <= '0;
      c     <= '0;
      oh    <= '0;
      ow    <= '0;
      slot  <= '0;
      end_r <= k_m1;
      end_c <= k_m1;
    end else if (accept) begin
      if (col_end) begin
        c     <= '0;
        ow    <= '0;
        end_c <= k_m1;
        if (row_end) begin
          r     <= '0;
          oh    <= '0;
          slot  <= '0;
          end_r <= k_m1;
        end else begin
          r    <= r + RW'(1);
          slot <= (32'(slot) == MAX_KERNEL - 1) ? '0 : slot + SW'(1);
          if (row_hit) begin
            end_r <= end_r + DW'(s_eff);
            oh    <= oh + RW'(1);
          end
        end
      end else begin
        c <= c + CW'(1);
        if (col_hit) begin
          end_c <= end_c + DW'(s_eff);
          ow    <= ow + CW'(1);
        end
      end
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/mpa_back.sv =====
// ----------------------------------------------------------------------------
// mpa_back: row maxima line buffers, column combine and result queue
// Stores each row maximum, merges the k rows of a finished window and
// queues the result for the receiver.
// ----------------------------------------------------------------------------
`default_nettype none

module mpa_back #(
  parameter int MAX_WIDTH  = mpa_pkg::DEF_MAX_WIDTH,
  parameter int MAX_KERNEL = mpa_pkg::DEF_MAX_KERNEL
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  mpa_pkg::hres_t               hres,
  input  wire logic [mpa_pkg::K_W-1:0] k_eff,
  input  wire logic                    pop,
  output logic                         full,
  output logic                         empty,
  output mpa_pkg::res_t                res
);

  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int SW    = (MAX_KERNEL > 1) ? $clog2(MAX_KERNEL) : 1;
  localparam int VW    = mpa_pkg::VAL_W;
  localparam int FW    = mpa_pkg::FW;
  localparam int OW    = mpa_pkg::OUT_W;
  localparam int QD    = mpa_pkg::Q_DEPTH;
  localparam int QA    = $clog2(QD);
  localparam int RAM_W = VW + CW;

  logic [RAM_W-1:0]     rdata [MAX_KERNEL];
  logic                 st_valid;
  mpa_pkg::hres_t       st;
  mpa_pkg::res_t        merged;
  mpa_pkg::res_t        q_mem [QD];
  logic [QA-1:0]        wptr, rptr;
  logic [QA:0]          count;
  logic                 do_pop;

  for (genvar i = 0; i < MAX_KERNEL; i++) begin : g_line
    mpa_ram #(
      .WIDTH(RAM_W),
      .DEPTH(MAX_WIDTH)
    ) u_ram (
      .clk  (clk),
      .we   (hres.wr && (32'(hres.slot) == i)),
      .waddr(hres.ow[CW-1:0]),
      .wdata({hres.val, hres.col[CW-1:0]}),
      .raddr(hres.ow[CW-1:0]),
      .rdata(rdata[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st_valid <= 1'b0;
    end else begin
      st_valid <= hres.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (hres.emit) begin
      st <= hres;
    end
  end

  // Oldest row first with strict compare so ties keep the earliest row.
  always_comb begin
    logic found;
    int   idx;
    logic signed [VW-1:0] cand_v;
    logic [FW-1:0] cand_c;
    logic signed [VW-1:0] best_v;
    logic [FW-1:0] best_r, best_c;
    found  = 1'b0;
    idx    = 0;
    best_v = st.val;
    best_r = st.row;
    best_c = st.col;
    for (int j = MAX_KERNEL - 1; j >= 0; j--) begin
      idx = 32'(st.slot) + MAX_KERNEL - j;
      if (idx >= MAX_KERNEL) begin
        idx = idx - MAX_KERNEL;
      end
      if (j == 0) begin
        cand_v = st.val;
        cand_c = st.col;
      end else begin
        cand_v = rdata[idx[SW-1:0]][RAM_W-1:CW];
        cand_c = FW'(rdata[idx[SW-1:0]][CW-1:0]);
      end
      if (mpa_pkg::K_W'(j) < k_eff) begin
        if (!found || cand_v > best_v) begin
          best_v = cand_v;
          best_r = st.row - FW'(j);
          best_c = cand_c;
          found  = 1'b1;
        end
      end
    end
    merged.val  = best_v;
    merged.wrow = best_r[OW-1:0];
    merged.wcol = best_c[OW-1:0];
    merged.orow = st.oh[OW-1:0];
    merged.ocol = st.ow[OW-1:0];
    merged.last = st.last;
  end

  assign do_pop = pop && (count != '0);
  assign empty  = (count == '0);
  // leave room for the result still in the merge stage
  assign full   = ((count + (QA+1)'(st_valid)) >= (QA+1)'(QD));
  assign res    = q_mem[rptr];

  always_ff @(posedge clk) begin
    if (st_valid) begin
      q_mem[wptr] <= merged;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (st_valid) begin
        wptr <= wptr + QA'(1);
      end
      if (do_pop) begin
        rptr <= rptr + QA'(1);
      end
      count <= count + (QA+1)'(st_valid) - (QA+1)'(do_pop);
    end
  end

endmodule

`default_nettype wire

// ===== verif/max_pool_2d_with_argmax_top_test.sv =====
// ----------------------------------------------------------------------------
// max_pool_2d_with_argmax_top_test: self-checking bench for the pooling top
// Streams image planes through the push/full side under several window
// setups, predicts every window maximum and winner position in the bench,
// and checks each result popped off the empty/pop side in order.
// ----------------------------------------------------------------------------
`default_nettype none

module max_pool_2d_with_argmax_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [mpa_pkg::IDX_W-1:0] REG_UNUSED = 3'd5;
  localparam int LINE_W     = 1024;
  localparam int LINE_ROWS  = 4;
  localparam int CYCLE_CAP  = 1000000;
  localparam int SETTLE     = 8;

  logic clk;
  logic rst;
  logic push;
  logic full;
  logic signed [mpa_pkg::VAL_W-1:0] sample;
  logic empty;
  logic pop;
  logic signed [mpa_pkg::VAL_W-1:0] max_value;
  logic [mpa_pkg::OUT_W-1:0] winner_row, winner_col, out_row, out_col;
  logic plane_done;
  logic cfg_valid;
  logic cfg_ready;
  logic [mpa_pkg::IDX_W-1:0] cfg_index;
  logic [mpa_pkg::CFG_W-1:0] cfg_data;

  max_pool_2d_with_argmax_top u_top (
    .clk(clk), .rst(rst), .push(push), .full(full), .sample(sample),
    .empty(empty), .pop(pop), .max_value(max_value), .winner_row(winner_row),
    .winner_col(winner_col), .out_row(out_row), .out_col(out_col),
    .plane_done(plane_done), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // bench copy of the block's registers, position and window store
  logic [mpa_pkg::CFG_W-1:0] height_reg, width_reg;
  logic [2:0] kernel_reg, stride_reg;
  int unsigned row_pos, col_pos;
  logic signed [mpa_pkg::VAL_W-1:0] win_max [LINE_ROWS*LINE_W];
  int unsigned win_row [LINE_ROWS*LINE_W];
  int unsigned win_col [LINE_ROWS*LINE_W];

  mpa_pkg::res_t window_q[$];
  int errors;
  int cycles;
  bit calm;
  int pop_hold;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_CAP) begin
      $display("max_pool_2d_with_argmax_top_test: done, errors");
      $finish;
    end
  end

  function automatic int gap_len();
    int p;
    p = $urandom_range(99);
    if (p < 70) return 0;
    if (p < 95) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  // receiver: random stalls, none while calm
  always @(posedge clk) begin
    int g;
    if (rst) begin
      pop <= 1'b0;
      pop_hold = 0;
    end else if (pop_hold > 0) begin
      pop <= 1'b0;
      pop_hold = pop_hold - 1;
    end else if (calm) begin
      pop <= 1'b1;
    end else begin
      g = gap_len();
      pop <= (g == 0);
      if (g > 0) pop_hold = g - 1;
    end
  end

  always @(posedge clk) begin
    mpa_pkg::res_t want;
    if (!rst && pop && !empty) begin
      if (window_q.size() == 0) begin
        $display("%0t: result with none expected: val %0d row %0d col %0d", $time,
                 max_value, out_row, out_col);
        errors++;
      end else begin
        want = window_q.pop_front();
        if (want.val !== max_value) begin
          $display("%0t: max_value exp %0d got %0d", $time, want.val, max_value);
          errors++;
        end
        if (want.wrow !== winner_row) begin
          $display("%0t: winner_row exp %0d got %0d", $time, want.wrow, winner_row);
          errors++;
        end
        if (want.wcol !== winner_col) begin
          $display("%0t: winner_col exp %0d got %0d", $time, want.wcol, winner_col);
          errors++;
        end
        if (want.orow !== out_row) begin
          $display("%0t: out_row exp %0d got %0d", $time, want.orow, out_row);
          errors++;
        end
        if (want.ocol !== out_col) begin
          $display("%0t: out_col exp %0d got %0d", $time, want.ocol, out_col);
          errors++;
        end
        if (want.last !== plane_done) begin
          $display("%0t: plane_done exp %0b got %0b", $time, want.last, plane_done);
          errors++;
        end
      end
    end
  end

  function automatic int unsigned fit(int unsigned len, int unsigned k, int unsigned s);
    if (len < k) return 0;
    return (len - k) / s + 1;
  endfunction

  // update window store for one sample, queue the result it closes
  function automatic void pool_sample(logic signed [mpa_pkg::VAL_W-1:0] v);
    int unsigned h, w, k, s, h_out, w_out, r, c, oh, ow, idx;
    mpa_pkg::res_t got;
    h = (height_reg == '0) ? 1 : ((32'(height_reg) > 1024) ? 1024 : 32'(height_reg));
    w = (width_reg == '0) ? 1 : ((32'(width_reg) > 1024) ? 1024 : 32'(width_reg));
    k = (kernel_reg == '0) ? 1 : ((32'(kernel_reg) > 4) ? 4 : 32'(kernel_reg));
    s = (stride_reg == '0) ? 1 : 32'(stride_reg);
    h_out = fit(h, k, s);
    w_out = fit(w, k, s);
    r = (row_pos >= h) ? h - 1 : row_pos;
    c = (col_pos >= w) ? w - 1 : col_pos;
    for (int ph = 0; ph < k; ph++) begin
      if (r < ph || (r - ph) % s != 0) continue;
      oh = (r - ph) / s;
      if (oh >= h_out) continue;
      for (int pw = 0; pw < k; pw++) begin
        if (c < pw || (c - pw) % s != 0) continue;
        ow = (c - pw) / s;
        if (ow >= w_out) continue;
        idx = (oh % LINE_ROWS) * LINE_W + ow;
        if ((ph == 0 && pw == 0) || v > win_max[idx]) begin
          win_max[idx] = v;
          win_row[idx] = r;
          win_col[idx] = c;
        end
        if (ph == k - 1 && pw == k - 1) begin
          got.val  = win_max[idx];
          got.wrow = mpa_pkg::OUT_W'(win_row[idx]);
          got.wcol = mpa_pkg::OUT_W'(win_col[idx]);
          got.orow = mpa_pkg::OUT_W'(oh);
          got.ocol = mpa_pkg::OUT_W'(ow);
          got.last = (oh == h_out - 1 && ow == w_out - 1);
          window_q.push_back(got);
        end
      end
    end
    c++;
    if (c >= w) begin
      c = 0;
      r++;
      if (r >= h) r = 0;
    end
    row_pos = r;
    col_pos = c;
  endfunction

  task automatic send_sample(logic signed [mpa_pkg::VAL_W-1:0] v, int gap);
    push <= 1'b1;
    sample <= v;
    do @(posedge clk); while (full);
    pool_sample(v);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain();
    push <= 1'b0;
    while (window_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(logic [mpa_pkg::IDX_W-1:0] idx, logic [mpa_pkg::CFG_W-1:0] val);
    push <= 1'b0;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
    unique case (idx)
      mpa_pkg::REG_HEIGHT: height_reg = val;
      mpa_pkg::REG_WIDTH:  width_reg = val;
      mpa_pkg::REG_KERNEL: kernel_reg = val[2:0];
      mpa_pkg::REG_STRIDE: stride_reg = val[2:0];
      default: return;
    endcase
    row_pos = 0;
    col_pos = 0;
  endtask

  task automatic setup(int h, int w, int k, int s);
    drain();
    write_reg(mpa_pkg::REG_HEIGHT, mpa_pkg::CFG_W'(h));
    write_reg(mpa_pkg::REG_WIDTH, mpa_pkg::CFG_W'(w));
    write_reg(mpa_pkg::REG_KERNEL, mpa_pkg::CFG_W'(k));
    write_reg(mpa_pkg::REG_STRIDE, mpa_pkg::CFG_W'(s));
  endtask

  function automatic logic signed [mpa_pkg::VAL_W-1:0] rand_sample();
    int p;
    p = $urandom_range(9);
    // small range to force ties
    if (p < 3) return mpa_pkg::VAL_W'(int'($urandom_range(3)) - 2);
    if (p == 3) return ($urandom_range(1) == 0) ? 16'sh7fff : 16'sh8000;
    return mpa_pkg::VAL_W'($urandom());
  endfunction

  task automatic test_extremes();
    logic signed [mpa_pkg::VAL_W-1:0] vals [16] = '{
      16'sh7fff, 16'sh8000, 16'sh8000, 16'sh7fff, 16'sd5, 16'sd5, 16'sd5, 16'sd5,
      16'sh8000, 16'sh8000, -16'sd1, 16'sd0, 16'sh5555, 16'shaaaa, 16'sh7ffe,
      16'sh7fff};
    setup(4, 4, 2, 2);
    foreach (vals[i]) send_sample(vals[i], 0);
  endtask

  task automatic test_kernel_too_big();
    setup(2, 2, 3, 1);
    for (int i = 0; i < 4; i++) send_sample(mpa_pkg::VAL_W'(32'h7fff - i), 0);
  endtask

  task automatic test_zero_and_unused();
    setup(0, 0, 0, 0);
    send_sample(16'sh1234, 0);
    drain();
    write_reg(REG_UNUSED, 11'h7ff);
    send_sample(16'sh8000, 1);
    send_sample(-16'sd7, 0);
  endtask

  task automatic test_saturation();
    setup(2047, 2047, 7, 7);
    for (int i = 0; i < 4; i++) send_sample(mpa_pkg::VAL_W'(i), 0);
    setup(3, 3, 1, 7);
    for (int i = 0; i < 5; i++) send_sample(mpa_pkg::VAL_W'(-i), 0);
  endtask

  task automatic test_tall_and_wide();
    setup(1024, 1, 1, 1);
    for (int i = 0; i < 512; i++) send_sample(mpa_pkg::VAL_W'($urandom()), gap_len());
    setup(1, 512, 1, 1);
    for (int i = 0; i < 512; i++) send_sample(mpa_pkg::VAL_W'($urandom()), gap_len());
  endtask

  task automatic test_random_planes();
    int sent, n, h, w, k, s;
    sent = 0;
    while (sent < 880) begin
      h = $urandom_range(12, 1);
      w = $urandom_range(12, 1);
      k = $urandom_range(4, 1);
      s = ($urandom_range(9) == 0) ? $urandom_range(7, 5) : $urandom_range(4, 1);
      if ($urandom_range(4) == 0) begin
        k = $urandom_range(3, 1);
        s = 1;
      end
      setup(h, w, k, s);
      calm = ($urandom_range(3) == 0);
      n = h * w * $urandom_range(3, 1);
      if ($urandom_range(3) == 0) n += $urandom_range(h * w);
      for (int i = 0; i < n; i++) send_sample(rand_sample(), calm ? 0 : gap_len());
      sent += n;
    end
    calm = 1'b0;
  endtask

  initial begin
    rst = 1'b1;
    push = 1'b0;
    sample = '0;
    cfg_valid = 1'b0;
    cfg_index = mpa_pkg::REG_HEIGHT;
    cfg_data = '0;
    errors = 0;
    cycles = 0;
    calm = 1'b0;
    height_reg = mpa_pkg::RST_HEIGHT;
    width_reg = mpa_pkg::RST_WIDTH;
    kernel_reg = mpa_pkg::RST_KERNEL;
    stride_reg = mpa_pkg::RST_STRIDE;
    row_pos = 0;
    col_pos = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_extremes();
    test_kernel_too_big();
    test_zero_and_unused();
    test_saturation();
    test_tall_and_wide();
    test_random_planes();
    drain();
    if (errors == 0) begin
      $display("max_pool_2d_with_argmax_top_test: done, clean");
    end else begin
      $display("max_pool_2d_with_argmax_top_test: done, errors");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== filelist.f =====
hw/rtl/mpa_pkg.sv
hw/rtl/mpa_ram.sv
hw/rtl/mpa_front.sv
hw/rtl/mpa_back.sv
hw/rtl/max_pool_2d_with_argmax_top.sv
verif/max_pool_2d_with_argmax_top_test.sv
